// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the extractor RTL.
// Included by the top level; compiles to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WMFX_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define WMFX_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define WMFX_ASSERT(lbl, clk, rstn, prop)
`define WMFX_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/wmfx_pkg.sv =====
// Types and constants for the WMF embedded-EMF extractor.
// No dependencies.
package wmfx_pkg;

  localparam logic [31:0] PLACEABLE_KEY = 32'h9AC6CDD7;
  localparam logic [31:0] WMFC_ID       = 32'h43464D57;
  localparam logic [15:0] FN_ESCAPE     = 16'h0626;
  localparam logic [15:0] ESC_EMF       = 16'h000F;
  localparam logic [31:0] EMF_SIG       = 32'h464D4520;
  localparam int unsigned CMT_HDR       = 34;
  localparam int unsigned EMF_MIN       = 52;
  localparam int unsigned PLACEABLE_LEN = 22;
  localparam int unsigned STD_HDR_LEN   = 18;
  localparam logic [15:0] WMF_VERSION   = 16'd9;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_RECORDS = 2'd1;
  localparam logic [1:0] PH_STOPPED = 2'd2;
  localparam logic [1:0] PH_FAILED  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HDR   = 3'd1;
  localparam logic [2:0] ST_BAD_REC   = 3'd2;
  localparam logic [2:0] ST_BAD_CMT   = 3'd3;
  localparam logic [2:0] ST_CHUNK     = 3'd4;
  localparam logic [2:0] ST_FINAL     = 3'd5;

  typedef struct packed {
    logic [2:0] status;
    logic       done_res;
    logic       payload_valid;
    logic [7:0] payload_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] cnt;
    item_t      first;
    item_t      second;
  } push_t;

endpackage

// ===== rtl/wmf_embedded_emf_extractor_top.sv =====
// Top level of the WMF embedded-EMF extractor: parser plus result queue.
// Depends on wmfx_pkg, wmfx_parser, wmfx_ofifo and assert_macros.svh.
//
// Takes one WMF byte per cycle while the queue has room and streams out the EMF
// payload of the enhanced-metafile escape records, followed by one status
// transfer (tlast) after the byte marked tlast. The parser sees the byte in
// the cycle it is taken and writes its results straight into a four-entry
// queue. Input is taken whenever the queue holds at most two transfers, so
// with a free-running output the block sustains one byte per clock. A nonzero
// status means the payload must be discarded.
`include "assert_macros.svh"
module wmf_embedded_emf_extractor_top #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status, rest zero
  output logic        m_axis_tuser,   // payload_valid
  output logic        m_axis_tlast    // done_res
);
  import wmfx_pkg::*;

  push_t      push;
  item_t      head;
  logic [2:0] count;
  logic       take;

  assign s_axis_tready = (count <= 3'd2);
  assign take          = s_axis_tvalid && s_axis_tready;

  wmfx_parser #(.COUNT_BITS(COUNT_BITS)) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .push_o      (push)
  );

  wmfx_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .count_o (count)
  );

  assign m_axis_tvalid = (count != 3'd0);
  assign m_axis_tdata  = {5'd0, head.status, head.payload_byte};
  assign m_axis_tuser  = head.payload_valid;
  assign m_axis_tlast  = head.done_res;

  `WMFX_ASSERT(a_count_bound, clk_i, rst_ni, count <= 3'd4)
  `WMFX_ASSERT_IMPL(a_no_push_idle, clk_i, rst_ni, !take, push.cnt == 2'd0)
  `WMFX_ASSERT_IMPL(a_status_kind, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
                    !m_axis_tuser)
  `WMFX_ASSERT_IMPL(a_payload_ok, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                    head.status == ST_OK)

endmodule

// ===== rtl/wmfx_parser.sv =====
// Record walker: state registers plus the per-byte update logic.
// Depends on wmfx_pkg.
module wmfx_parser #(
  parameter int COUNT_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output wmfx_pkg::push_t  push_o
);
  import wmfx_pkg::*;

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  logic [5:0]            sp_q, sp_d;
  logic                  pf_q, pf_d;
  logic [31:0]           rp_q, rp_d;
  logic [32:0]           len_q, len_d;
  logic [15:0]           fn_q, fn_d;
  logic [31:0]           fa_q, fa_d;
  logic [15:0]           cf0_q, cf0_d;
  logic [31:0]           cf1_q, cf1_d, cf2_q, cf2_d, cf3_q, cf3_d;
  logic [31:0]           ech_q, ech_d, esz_q, esz_d;
  logic [COUNT_BITS-1:0] cs_q, cs_d, be_q, be_d;
  logic [31:0]           sg0_q, sg0_d, sg1_q, sg1_d, sg2_q, sg2_d;
  logic [1:0]            ph_q, ph_d;
  logic                  ic_q, ic_d;
  logic [2:0]            fc_q, fc_d;

  logic [5:0]  hdr;
  logic [15:0] hi;
  logic [32:0] r33, avail, es33, be33, cs33;
  logic        emit;
  logic [2:0]  st;
  item_t       pay, stat;

  always_comb begin
    sp_d = sp_q; pf_d = pf_q; rp_d = rp_q; len_d = len_q; fn_d = fn_q; fa_d = fa_q;
    cf0_d = cf0_q; cf1_d = cf1_q; cf2_d = cf2_q; cf3_d = cf3_q;
    ech_d = ech_q; esz_d = esz_q; cs_d = cs_q; be_d = be_q;
    sg0_d = sg0_q; sg1_d = sg1_q; sg2_d = sg2_q;
    ph_d = ph_q; ic_d = ic_q; fc_d = fc_q;
    emit = 1'b0; hdr = '0; hi = '0; r33 = '0; avail = '0; es33 = '0;
    be33 = '0; cs33 = '0; st = ST_OK;

    if (ph_q == PH_HEADER || ph_q == PH_RECORDS) begin
      fa_d = {data_byte_i, fa_q[31:8]};
    end
    hi = fa_d[31:16];

    if (ph_q == PH_HEADER) begin
      if (sp_q == 6'd3) begin
        pf_d = (fa_d == PLACEABLE_KEY);
      end
      hdr = pf_d ? 6'(PLACEABLE_LEN) : 6'd0;
      if (sp_q == hdr + 6'd3 && hi != WMF_VERSION) begin
        ph_d = PH_FAILED; fc_d = ST_BAD_HDR;
      end else if (sp_q == hdr + 6'(STD_HDR_LEN - 1)) begin
        ph_d = PH_RECORDS; rp_d = '0; ic_d = 1'b0;
      end
      if (sp_q != 6'h3F) sp_d = sp_q + 6'd1;
    end else if (ph_q == PH_RECORDS) begin
      r33 = {1'b0, rp_q};
      if (rp_q == 32'd3) begin
        len_d = {fa_d, 1'b0};
      end else if (rp_q == 32'd5) begin
        fn_d = hi;
        if (len_q < 33'd6) begin
          ph_d = PH_FAILED; fc_d = ST_BAD_REC;
        end
      end else if (rp_q == 32'd7) begin
        ic_d = (fn_q == FN_ESCAPE) && (len_q >= 33'(10 + CMT_HDR)) && (hi == ESC_EMF);
      end else if (ic_q) begin
        if (rp_q == 32'd9) begin
          cf0_d = hi;
          if (hi < 16'(CMT_HDR) || ({17'd0, hi} + 33'd10) > len_q) begin
            ph_d = PH_FAILED; fc_d = ST_BAD_CMT;
          end
        end else if (rp_q == 32'd13) begin
          if (fa_d != WMFC_ID) begin
            ph_d = PH_FAILED; fc_d = ST_BAD_CMT;
          end
        end else if (rp_q == 32'd17) begin
          if (fa_d != 32'd1) begin
            ph_d = PH_FAILED; fc_d = ST_BAD_CMT;
          end
        end else if (rp_q == 32'd31) begin
          cf1_d = fa_d;
        end else if (rp_q == 32'd35) begin
          cf2_d = fa_d;
        end else if (rp_q == 32'd39) begin
          cf3_d = fa_d;
        end else if (rp_q == 32'd43) begin
          if (({1'b0, cf2_q} + 33'(CMT_HDR)) > {17'd0, cf0_q} || fa_d < cf3_q) begin
            ph_d = PH_FAILED; fc_d = ST_BAD_CMT;
          end else if (cs_q != '0 && (cf1_q != ech_q || fa_d != esz_q)) begin
            ph_d = PH_FAILED; fc_d = ST_CHUNK;
          end else begin
            if (cs_q == '0) begin
              ech_d = cf1_q; esz_d = fa_d;
            end
            es33 = {1'b0, esz_d};
            be33 = 33'(be_q);
            avail = (es33 >= be33) ? es33 - be33 : '0;
            if ({1'b0, cf2_q} > avail || ({1'b0, cf3_q} + {1'b0, cf2_q}) != avail) begin
              ph_d = PH_FAILED; fc_d = ST_CHUNK;
            end else if (cs_q != CMAX) begin
              cs_d = cs_q + COUNT_BITS'(1);
            end
          end
        end else if (rp_q >= 32'd44 && r33 < ({1'b0, cf2_q} + 33'd44)) begin
          emit = 1'b1;
          if (be_q < COUNT_BITS'(4)) begin
            sg0_d = sg0_q | (32'(data_byte_i) << {be_q[1:0], 3'b000});
          end else if (be_q >= COUNT_BITS'(40) && be_q < COUNT_BITS'(44)) begin
            sg1_d = sg1_q | (32'(data_byte_i) << {be_q[1:0], 3'b000});
          end else if (be_q >= COUNT_BITS'(48) && be_q < COUNT_BITS'(52)) begin
            sg2_d = sg2_q | (32'(data_byte_i) << {be_q[1:0], 3'b000});
          end
          if (be_q != CMAX) be_d = be_q + COUNT_BITS'(1);
        end
      end
      if (ph_d == PH_RECORDS) begin
        if (rp_q >= 32'd5 && (r33 + 33'd1) == len_d) begin
          if (fn_d == 16'd0) begin
            ph_d = PH_STOPPED;
          end else begin
            rp_d = '0; ic_d = 1'b0;
          end
        end else if (rp_q != 32'hFFFF_FFFF) begin
          rp_d = rp_q + 32'd1;
        end
      end
    end

    cs33 = 33'(cs_d);
    be33 = 33'(be_d);
    if (ph_d == PH_FAILED) begin
      st = fc_d;
    end else if (ph_d == PH_HEADER) begin
      st = ST_BAD_HDR;
    end else if (ph_d == PH_RECORDS && rp_d >= 32'd6) begin
      st = ST_BAD_REC;
    end else if (cs_d == '0 || cs33 != {1'b0, ech_d} || be33 != {1'b0, esz_d}
                 || be33 < 33'(EMF_MIN) || sg0_d != 32'd1 || sg1_d != EMF_SIG
                 || {1'b0, sg2_d} != be33) begin
      st = ST_FINAL;
    end

    pay  = '{status: ST_OK, done_res: 1'b0, payload_valid: 1'b1, payload_byte: data_byte_i};
    stat = '{status: st, done_res: 1'b1, payload_valid: 1'b0, payload_byte: 8'd0};
    push_o.cnt    = 2'(emit) + 2'(last_byte_i);
    push_o.first  = emit ? pay : stat;
    push_o.second = stat;
    if (!take_i) push_o.cnt = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0; pf_q <= 1'b0; rp_q <= '0; len_q <= '0; fn_q <= '0; fa_q <= '0;
      cf0_q <= '0; cf1_q <= '0; cf2_q <= '0; cf3_q <= '0;
      ech_q <= '0; esz_q <= '0; cs_q <= '0; be_q <= '0;
      sg0_q <= '0; sg1_q <= '0; sg2_q <= '0; ic_q <= 1'b0; fc_q <= ST_OK;
      ph_q <= PH_HEADER;
    end else if (take_i) begin
      if (last_byte_i) begin
        sp_q <= '0; pf_q <= 1'b0; rp_q <= '0; len_q <= '0; fn_q <= '0; fa_q <= '0;
        cf0_q <= '0; cf1_q <= '0; cf2_q <= '0; cf3_q <= '0;
        ech_q <= '0; esz_q <= '0; cs_q <= '0; be_q <= '0;
        sg0_q <= '0; sg1_q <= '0; sg2_q <= '0; ic_q <= 1'b0; fc_q <= ST_OK;
        ph_q <= PH_HEADER;
      end else begin
        sp_q <= sp_d; pf_q <= pf_d; rp_q <= rp_d; len_q <= len_d; fn_q <= fn_d;
        fa_q <= fa_d; cf0_q <= cf0_d; cf1_q <= cf1_d; cf2_q <= cf2_d; cf3_q <= cf3_d;
        ech_q <= ech_d; esz_q <= esz_d; cs_q <= cs_d; be_q <= be_d;
        sg0_q <= sg0_d; sg1_q <= sg1_d; sg2_q <= sg2_d; ic_q <= ic_d; fc_q <= fc_d;
        ph_q <= ph_d;
      end
    end
  end

endmodule

// ===== rtl/wmfx_ofifo.sv =====
// Four-entry result queue with a two-item write port.
// Depends on wmfx_pkg.
module wmfx_ofifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wmfx_pkg::push_t push_i,
  input  logic            pop_i,
  output wmfx_pkg::item_t head_o,
  output logic [2:0]      count_o
);
  import wmfx_pkg::*;

  item_t      mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop     = pop_i && (cnt_q != 3'd0);
  assign head_o  = mem_q[rp_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wp_q] <= push_i.first;
    if (push_i.cnt == 2'd2) mem_q[wp_q + 2'd1] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + push_i.cnt;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_i.cnt) - 3'(pop);
    end
  end

endmodule
